@@ rtl/core/tkmp_pkg.sv @@
package tkmp_pkg;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_KEY  = 2'd1,
      CMD_SW1  = 2'd2,
      CMD_SW2  = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_TICKS_PER_UNIT = 1'b0,
      CSR_SONG_GAP_UNITS = 1'b1
   } csr_index_type;

   localparam int TPU_W      = 23;
   localparam int GAP_W      = 8;
   localparam int HALF_W     = 17;
   localparam int IDX_W      = 6;
   localparam int POS_W      = 7;
   localparam int TONE_COUNT = 38;
   localparam int NOTES_PER_OCTAVE = 12;
   localparam logic [7:0] REST_TONE = 8'd255;
   localparam logic [2:0] NO_KEY    = 3'd4;
   localparam logic [TPU_W-1:0] TPU_RESET = 23'd400000;
   localparam logic [GAP_W-1:0] GAP_RESET = 8'd10;

   // Playback state that does not depend on any module parameter.
   typedef struct packed {
      logic [2:0]        held_key;
      logic [IDX_W-1:0]  score_index;
      logic [HALF_W-1:0] half_count;
      logic [TPU_W-1:0]  unit_count;
      logic [7:0]        units_left;
      logic              gap_active;
      logic              tone_on;
      logic              speaker;
   } play_type;

   localparam logic [HALF_W-1:0] TONE_HALF [TONE_COUNT] = '{
      17'd76336, 17'd72202, 17'd68028, 17'd64308, 17'd60790, 17'd57306,
      17'd54054, 17'd51020, 17'd48192, 17'd45454, 17'd42918, 17'd40486,
      17'd38240, 17'd36102, 17'd34072, 17'd32154, 17'd30350, 17'd28654,
      17'd27028, 17'd25510, 17'd24068, 17'd22728, 17'd21460, 17'd20242,
      17'd19120, 17'd18050, 17'd17036, 17'd16078, 17'd15174, 17'd14326,
      17'd13522, 17'd12764, 17'd12048, 17'd11364, 17'd10730, 17'd10126,
      17'd9560,  17'd9026
   };

   // Score words: tone in the high byte, duration units in the low byte.
   localparam int SONG0_LEN = 25;
   localparam int SONG1_LEN = 42;
   localparam int SONG2_LEN = 25;
   localparam int SONG3_LEN = 26;

   localparam logic [15:0] SONG0 [SONG0_LEN] = '{
      16'h0404, 16'h0204, 16'h0004, 16'h0204, 16'h0404, 16'h0404, 16'h0408,
      16'h0204, 16'h0204, 16'h0208, 16'h0404, 16'h0704, 16'h0708,
      16'h0404, 16'h0204, 16'h0004, 16'h0204, 16'h0404, 16'h0404, 16'h0408,
      16'h0204, 16'h0204, 16'h0404, 16'h0204, 16'h0008
   };

   localparam logic [15:0] SONG1 [SONG1_LEN] = '{
      16'h0004, 16'h0004, 16'h0704, 16'h0704, 16'h0904, 16'h0904, 16'h0708,
      16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0204, 16'h0204, 16'h0008,
      16'h0704, 16'h0704, 16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0208,
      16'h0704, 16'h0704, 16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0208,
      16'h0004, 16'h0004, 16'h0704, 16'h0704, 16'h0904, 16'h0904, 16'h0708,
      16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0204, 16'h0204, 16'h0008
   };

   localparam logic [15:0] SONG2 [SONG2_LEN] = '{
      16'h0002, 16'h0002, 16'h0204, 16'h0004, 16'h0504, 16'h0408, 16'h0002,
      16'h0002, 16'h0204, 16'h0004, 16'h0704, 16'h0508, 16'h0002, 16'h0002,
      16'h0C04, 16'h0904, 16'h0504, 16'h0404, 16'h0208, 16'h0B02, 16'h0B02,
      16'h0904, 16'h0504, 16'h0704, 16'h050C
   };

   localparam logic [15:0] SONG3 [SONG3_LEN] = '{
      16'h0404, 16'h0B04, 16'h0904, 16'h0404, 16'h0806, 16'h0806, 16'h0908,
      16'h0404, 16'h0904, 16'h0404, 16'h0806, 16'h0806, 16'h0904,
      16'h0404, 16'h0B04, 16'h0904, 16'h0404, 16'h0806, 16'h0806, 16'h0908,
      16'h0404, 16'h0904, 16'h0D04, 16'h0B06, 16'h0905, 16'h0B05
   };

   // Entries past the end of a song read as zero, which ends the song.
   function automatic logic [15:0] score_word(input logic [1:0] song,
                                              input logic [IDX_W-1:0] idx);
      logic [15:0] word;
      word = 16'h0000;
      case (song)
         2'd0: if (idx < IDX_W'(SONG0_LEN)) word = SONG0[idx[4:0]];
         2'd1: if (idx < IDX_W'(SONG1_LEN)) word = SONG1[idx];
         2'd2: if (idx < IDX_W'(SONG2_LEN)) word = SONG2[idx[4:0]];
         2'd3: if (idx < IDX_W'(SONG3_LEN)) word = SONG3[idx[4:0]];
         default: word = 16'h0000;
      endcase
      return word;
   endfunction

   function automatic logic [2:0] key_semitone(input logic [1:0] k);
      logic [2:0] s;
      case (k)
         2'd0: s = 3'd0;
         2'd1: s = 3'd2;
         2'd2: s = 3'd4;
         2'd3: s = 3'd5;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/core/tkmp_step.sv @@
module tkmp_step #(
   parameter int SCORE_DEPTH  = 128,
   parameter int SONG_COUNT   = 4,
   parameter int OCTAVE_COUNT = 3,
   parameter int SONG_W       = 2
) (
   input  tkmp_pkg::cmd_type            cmd,
   input  logic [1:0]                   key,
   input  logic [tkmp_pkg::TPU_W-1:0]   ticks_per_unit,
   input  logic [tkmp_pkg::GAP_W-1:0]   song_gap_units,
   input  logic                         mode,
   input  logic [1:0]                   octave,
   input  logic [SONG_W-1:0]            song,
   input  logic [3:0]                   key_flags,
   input  tkmp_pkg::play_type           play,
   output logic                         mode_in,
   output logic [1:0]                   octave_in,
   output logic [SONG_W-1:0]            song_in,
   output logic [3:0]                   key_flags_in,
   output tkmp_pkg::play_type           play_in
);

   logic [tkmp_pkg::TPU_W-1:0]  tpu;
   logic [tkmp_pkg::IDX_W-1:0]  lookup_idx;
   logic                        entry_ok;
   logic [15:0]                 entry;
   logic [7:0]                  entry_tone;
   logic [7:0]                  entry_dur;
   logic [4:0]                  oct_offset;
   logic [8:0]                  score_pitch;
   logic                        score_pitch_ok;
   logic [2:0]                  first_key;
   logic [2:0]                  piano_key;
   logic [8:0]                  pitch;
   logic                        pitch_ok;
   logic [tkmp_pkg::HALF_W-1:0] half_period;
   logic [3:0]                  flags_toggled;

   assign tpu = (ticks_per_unit == '0) ? tkmp_pkg::TPU_W'(1) : ticks_per_unit;
   assign oct_offset = 5'(octave) * 5'(tkmp_pkg::NOTES_PER_OCTAVE);

   // A finished gap rewinds the score before the entry is fetched.
   assign lookup_idx = (play.units_left == 8'd0 && play.gap_active) ? '0 : play.score_index;
   assign entry_ok = (32'(song) < 32'd4) && (32'(lookup_idx) < 32'(SCORE_DEPTH));
   assign entry = entry_ok ? tkmp_pkg::score_word(2'(song), lookup_idx) : 16'h0000;
   assign entry_tone = entry[15:8];
   assign entry_dur  = entry[7:0];
   assign score_pitch = {1'b0, entry_tone} + 9'(oct_offset);
   assign score_pitch_ok = (entry_tone != tkmp_pkg::REST_TONE) &&
                           (score_pitch < 9'(tkmp_pkg::TONE_COUNT));

   always_comb begin
      if (key_flags[0])      first_key = 3'd0;
      else if (key_flags[1]) first_key = 3'd1;
      else if (key_flags[2]) first_key = 3'd2;
      else if (key_flags[3]) first_key = 3'd3;
      else                   first_key = tkmp_pkg::NO_KEY;
   end

   assign piano_key = (play.held_key == tkmp_pkg::NO_KEY) ? first_key : play.held_key;
   assign pitch = mode ? score_pitch
                       : 9'(tkmp_pkg::key_semitone(piano_key[1:0])) + 9'(oct_offset);
   assign pitch_ok = pitch < 9'(tkmp_pkg::TONE_COUNT);
   assign half_period = pitch_ok ? tkmp_pkg::TONE_HALF[pitch[5:0]] : '0;
   assign flags_toggled = key_flags ^ (4'b0001 << key);

   always_comb begin
      mode_in      = mode;
      octave_in    = octave;
      song_in      = song;
      key_flags_in = key_flags;
      play_in      = play;
      case (cmd)
         tkmp_pkg::CMD_TICK: begin
            if (!mode) begin
               if (play.held_key == tkmp_pkg::NO_KEY && first_key != tkmp_pkg::NO_KEY) begin
                  play_in.held_key   = first_key;
                  play_in.tone_on    = 1'b1;
                  play_in.half_count = '0;
               end
            end else begin
               if (play.units_left == 8'd0) begin
                  play_in.score_index = lookup_idx;
                  play_in.gap_active  = 1'b0;
                  play_in.unit_count  = '0;
                  play_in.half_count  = '0;
                  if (entry_dur == 8'd0) begin
                     play_in.tone_on    = 1'b0;
                     play_in.gap_active = 1'b1;
                     play_in.units_left = song_gap_units;
                  end else begin
                     play_in.units_left = entry_dur;
                     play_in.tone_on    = score_pitch_ok;
                  end
               end
               // The end-of-song load starts the gap without counting a tick.
               if (!(play.units_left == 8'd0 && entry_dur == 8'd0)) begin
                  if ({1'b0, play_in.unit_count} + 24'd1 >= {1'b0, tpu}) begin
                     play_in.unit_count = '0;
                     play_in.units_left = play_in.units_left - 8'd1;
                     if (play_in.units_left == 8'd0 && !play_in.gap_active) begin
                        play_in.tone_on     = 1'b0;
                        play_in.score_index = play_in.score_index + tkmp_pkg::IDX_W'(1);
                     end
                  end else begin
                     play_in.unit_count = play_in.unit_count + tkmp_pkg::TPU_W'(1);
                  end
               end
            end
            if (play_in.tone_on && pitch_ok) begin
               if ({1'b0, play_in.half_count} + 18'd1 >= {1'b0, half_period}) begin
                  play_in.half_count = '0;
                  play_in.speaker    = ~play.speaker;
               end else begin
                  play_in.half_count = play_in.half_count + tkmp_pkg::HALF_W'(1);
               end
            end
         end
         tkmp_pkg::CMD_KEY: begin
            key_flags_in = flags_toggled;
            if (!mode && play.held_key == {1'b0, key} && !flags_toggled[key]) begin
               play_in.held_key = tkmp_pkg::NO_KEY;
               play_in.tone_on  = 1'b0;
            end
         end
         tkmp_pkg::CMD_SW1: begin
            if (!mode) begin
               octave_in = (octave == 2'(OCTAVE_COUNT - 1)) ? 2'd0 : octave + 2'd1;
            end else begin
               song_in = (song == SONG_W'(SONG_COUNT - 1)) ? '0 : song + SONG_W'(1);
               play_in.tone_on     = 1'b0;
               play_in.score_index = '0;
               play_in.unit_count  = '0;
               play_in.half_count  = '0;
               play_in.gap_active  = 1'b1;
               play_in.units_left  = song_gap_units;
            end
         end
         tkmp_pkg::CMD_SW2: begin
            mode_in             = ~mode;
            play_in.tone_on     = 1'b0;
            play_in.held_key    = tkmp_pkg::NO_KEY;
            play_in.score_index = '0;
            play_in.half_count  = '0;
            play_in.unit_count  = '0;
            play_in.units_left  = '0;
            play_in.gap_active  = 1'b0;
         end
         default: begin
            play_in = play;
         end
      endcase
   end

endmodule

@@ rtl/core/tkmp_rsp_reg.sv @@
module tkmp_rsp_reg #(
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [DATA_W-1:0] data,
   output logic              ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata
);

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] data_ff;

   // A new result may replace one that is being taken in the same cycle.
   assign ready    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

@@ rtl/core/tone_keyboard_and_melody_player_top.sv @@
// Square-wave tone player with a four-key piano mode and a four-song autoplay mode.
// Input channel (req_): req_tuser carries the command (tick, key toggle, SW1, SW2)
// and req_tdata the key number for key toggles. Each tick stands for one clock of
// the tone time base, so ticks are expected once per cycle.
// Result channel (rsp_): one result per input transfer with the speaker level,
// tone flag, mode, octave, song and score position after that item.
// A result is registered and shows on rsp_tvalid in the cycle after its input;
// one item is taken every cycle; the state update is a single combinational
// pass (score ROM, tone ROM and two counter compares) before the state registers.
// When the receiver stalls, the result waits in the output register and
// req_tready drops until it is taken; no item is lost or repeated.
// The csr_ port writes ticks_per_unit (index 0) and song_gap_units (index 1);
// write it only while no transfer is in flight.
// Synchronous reset returns to piano mode, octave 0, song 0, all keys released,
// silent speaker at level 0, ticks_per_unit 400000 and song_gap_units 10.
module tone_keyboard_and_melody_player_top #(
   parameter int SCORE_DEPTH  = 128,
   parameter int SONG_COUNT   = 4,
   parameter int OCTAVE_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] key, zero padded
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // speaker, tone_on, mode_now, octave_now[1:0],
                                    // song_now[1:0], note_pos[6:0], zero padded
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [22:0] csr_wdata
);

   localparam int SONG_W = (SONG_COUNT > 1) ? $clog2(SONG_COUNT) : 1;

   logic [tkmp_pkg::TPU_W-1:0] tpu_ff;
   logic [tkmp_pkg::GAP_W-1:0] gap_ff;
   logic                       mode_ff;
   logic                       mode_in;
   logic [1:0]                 octave_ff;
   logic [1:0]                 octave_in;
   logic [SONG_W-1:0]          song_ff;
   logic [SONG_W-1:0]          song_in;
   logic [3:0]                 key_flags_ff;
   logic [3:0]                 key_flags_in;
   tkmp_pkg::play_type         play_ff;
   tkmp_pkg::play_type         play_in;
   logic                       accept;
   logic [15:0]                rsp_word;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= tkmp_pkg::TPU_RESET;
         gap_ff <= tkmp_pkg::GAP_RESET;
      end else if (csr_we) begin
         case (tkmp_pkg::csr_index_type'(csr_index))
            tkmp_pkg::CSR_TICKS_PER_UNIT: tpu_ff <= csr_wdata;
            tkmp_pkg::CSR_SONG_GAP_UNITS: gap_ff <= csr_wdata[tkmp_pkg::GAP_W-1:0];
            default: tpu_ff <= tpu_ff;
         endcase
      end
   end

   tkmp_step #(
      .SCORE_DEPTH  (SCORE_DEPTH),
      .SONG_COUNT   (SONG_COUNT),
      .OCTAVE_COUNT (OCTAVE_COUNT),
      .SONG_W       (SONG_W)
   ) u_step (
      .cmd            (tkmp_pkg::cmd_type'(req_tuser)),
      .key            (req_tdata[1:0]),
      .ticks_per_unit (tpu_ff),
      .song_gap_units (gap_ff),
      .mode           (mode_ff),
      .octave         (octave_ff),
      .song           (song_ff),
      .key_flags      (key_flags_ff),
      .play           (play_ff),
      .mode_in        (mode_in),
      .octave_in      (octave_in),
      .song_in        (song_in),
      .key_flags_in   (key_flags_in),
      .play_in        (play_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= 1'b0;
         octave_ff            <= 2'd0;
         song_ff              <= '0;
         key_flags_ff         <= 4'd0;
         play_ff.held_key     <= tkmp_pkg::NO_KEY;
         play_ff.score_index  <= '0;
         play_ff.half_count   <= '0;
         play_ff.unit_count   <= '0;
         play_ff.units_left   <= '0;
         play_ff.gap_active   <= 1'b0;
         play_ff.tone_on      <= 1'b0;
         play_ff.speaker      <= 1'b0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         octave_ff    <= octave_in;
         song_ff      <= song_in;
         key_flags_ff <= key_flags_in;
         play_ff      <= play_in;
      end
   end

   assign rsp_word = {2'b00,
                      tkmp_pkg::POS_W'(play_in.score_index),
                      2'(song_in),
                      octave_in,
                      mode_in,
                      play_in.tone_on,
                      play_in.speaker};

   tkmp_rsp_reg #(
      .DATA_W (16)
   ) u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .data       (rsp_word),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int OCTAVES        = 3;
   localparam int TONES          = 38;
   localparam int REST           = 255;
   localparam logic [2:0] NONE_HELD = 3'd4;

   // Half periods in clock ticks, lowest tone first.
   localparam int HALF_PERIOD [TONES] = '{
      76336, 72202, 68028, 64308, 60790, 57306, 54054, 51020, 48192, 45454, 42918, 40486,
      38240, 36102, 34072, 32154, 30350, 28654, 27028, 25510, 24068, 22728, 21460, 20242,
      19120, 18050, 17036, 16078, 15174, 14326, 13522, 12764, 12048, 11364, 10730, 10126,
      9560, 9026
   };
   localparam int KEY_STEP [4] = '{0, 2, 4, 5};

   // All four scores back to back, each word {tone, duration}.
   localparam int TUNE_START [4] = '{0, 25, 67, 92};
   localparam int TUNE_LEN   [4] = '{25, 42, 25, 26};
   localparam logic [15:0] TUNE_WORDS [118] = '{
      // song 0
      16'h0404, 16'h0204, 16'h0004, 16'h0204, 16'h0404, 16'h0404, 16'h0408,
      16'h0204, 16'h0204, 16'h0208, 16'h0404, 16'h0704, 16'h0708,
      16'h0404, 16'h0204, 16'h0004, 16'h0204, 16'h0404, 16'h0404, 16'h0408,
      16'h0204, 16'h0204, 16'h0404, 16'h0204, 16'h0008,
      // song 1
      16'h0004, 16'h0004, 16'h0704, 16'h0704, 16'h0904, 16'h0904, 16'h0708,
      16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0204, 16'h0204, 16'h0008,
      16'h0704, 16'h0704, 16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0208,
      16'h0704, 16'h0704, 16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0208,
      16'h0004, 16'h0004, 16'h0704, 16'h0704, 16'h0904, 16'h0904, 16'h0708,
      16'h0504, 16'h0504, 16'h0404, 16'h0404, 16'h0204, 16'h0204, 16'h0008,
      // song 2
      16'h0002, 16'h0002, 16'h0204, 16'h0004, 16'h0504, 16'h0408, 16'h0002,
      16'h0002, 16'h0204, 16'h0004, 16'h0704, 16'h0508, 16'h0002, 16'h0002,
      16'h0C04, 16'h0904, 16'h0504, 16'h0404, 16'h0208, 16'h0B02, 16'h0B02,
      16'h0904, 16'h0504, 16'h0704, 16'h050C,
      // song 3
      16'h0404, 16'h0B04, 16'h0904, 16'h0404, 16'h0806, 16'h0806, 16'h0908,
      16'h0404, 16'h0904, 16'h0404, 16'h0806, 16'h0806, 16'h0904,
      16'h0404, 16'h0B04, 16'h0904, 16'h0404, 16'h0806, 16'h0806, 16'h0908,
      16'h0404, 16'h0904, 16'h0D04, 16'h0B06, 16'h0905, 16'h0B05
   };

   // Same layout as rsp_tdata[13:0], highest field first.
   typedef struct packed {
      logic [6:0] pos;
      logic [1:0] song;
      logic [1:0] octave;
      logic       mode;
      logic       tone_on;
      logic       speaker;
   } status_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [1:0] key, zero padded
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // speaker, tone_on, mode_now, octave_now[1:0],
                             // song_now[1:0], note_pos[6:0], zero padded
   logic        csr_we;
   tkmp_pkg::csr_index_type csr_index;
   logic [22:0] csr_wdata;

   status_type expected_status [$];
   int errors;
   int results_seen;
   int idle_cycles;
   int send_idle_pct;
   int recv_stall_pct;

   // Player state as the block should hold it.
   logic        m_mode;
   logic [1:0]  m_octave;
   logic [1:0]  m_song;
   logic [3:0]  m_keys;
   logic [2:0]  m_held;
   int          m_index;
   int          m_half;
   int          m_unit;
   int          m_left;
   logic        m_gap;
   logic        m_speaker;
   logic        m_tone;
   logic [22:0] r_tpu;
   logic [7:0]  r_gap;

   tone_keyboard_and_melody_player_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void score_at(output int tone, output int dur);
      logic [15:0] word;
      word = 16'h0000;
      if (m_index < TUNE_LEN[m_song])
         word = TUNE_WORDS[TUNE_START[m_song] + m_index];
      tone = word[15:8];
      dur  = word[7:0];
   endfunction

   function automatic void clear_playback();
      m_tone  = 1'b0;
      m_held  = NONE_HELD;
      m_index = 0;
      m_half  = 0;
      m_unit  = 0;
      m_left  = 0;
      m_gap   = 1'b0;
   endfunction

   function automatic void clock_tick();
      int tone;
      int dur;
      int idx;
      int tpu;
      if (!m_mode) begin
         if (m_held == NONE_HELD) begin
            for (int k = 0; k < 4 && m_held == NONE_HELD; k++) begin
               if (m_keys[k]) begin
                  m_held = 3'(k);
                  m_tone = 1'b1;
                  m_half = 0;
               end
            end
         end
      end else begin
         tpu = (r_tpu == 0) ? 1 : int'(r_tpu);
         if (m_left == 0) begin
            if (m_gap) begin
               m_gap   = 1'b0;
               m_index = 0;
            end
            score_at(tone, dur);
            m_unit = 0;
            m_half = 0;
            // A zero duration ends the song and opens the gap; nothing sounds.
            if (dur == 0) begin
               m_tone = 1'b0;
               m_gap  = 1'b1;
               m_left = r_gap;
               return;
            end
            m_left = dur;
            m_tone = (tone != REST && tone + 12 * m_octave < TONES);
         end
         if (m_unit + 1 >= tpu) begin
            m_unit = 0;
            m_left--;
            if (m_left == 0 && !m_gap) begin
               m_tone = 1'b0;
               m_index++;
            end
         end else begin
            m_unit++;
         end
      end
      if (m_tone) begin
         if (m_mode) begin
            score_at(tone, dur);
            idx = tone + 12 * m_octave;
         end else begin
            idx = KEY_STEP[m_held[1:0]] + 12 * m_octave;
         end
         if (idx < TONES) begin
            if (m_half + 1 >= HALF_PERIOD[idx]) begin
               m_half    = 0;
               m_speaker = ~m_speaker;
            end else begin
               m_half++;
            end
         end
      end
   endfunction

   function automatic void advance_player(tkmp_pkg::cmd_type c, logic [1:0] k);
      case (c)
         tkmp_pkg::CMD_TICK: clock_tick();
         tkmp_pkg::CMD_KEY: begin
            m_keys[k] = ~m_keys[k];
            if (!m_mode && m_held == {1'b0, k} && !m_keys[k]) begin
               m_held = NONE_HELD;
               m_tone = 1'b0;
            end
         end
         tkmp_pkg::CMD_SW1: begin
            if (!m_mode) begin
               m_octave = 2'((m_octave + 1) % OCTAVES);
            end else begin
               m_song  = m_song + 2'd1;
               m_tone  = 1'b0;
               m_index = 0;
               m_unit  = 0;
               m_half  = 0;
               m_gap   = 1'b1;
               m_left  = r_gap;
            end
         end
         default: begin
            m_mode = ~m_mode;
            clear_playback();
         end
      endcase
      expected_status.push_back('{7'(m_index), m_song, m_octave, m_mode, m_tone,
                                  m_speaker});
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch in result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
   endtask

   task automatic send_item(tkmp_pkg::cmd_type c, logic [1:0] k);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {6'b0, k};
      do @(posedge clock); while (!req_tready);
      advance_player(c, k);
   endtask

   task automatic send_ticks(int n);
      for (int i = 0; i < n; i++) send_item(tkmp_pkg::CMD_TICK, 2'd0);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   // Registers change only with no transfer in flight.
   task automatic set_registers(logic [22:0] tpu, logic [7:0] gap);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= tkmp_pkg::CSR_TICKS_PER_UNIT;
      csr_wdata <= tpu;
      @(posedge clock);
      csr_index <= tkmp_pkg::CSR_SONG_GAP_UNITS;
      csr_wdata <= {15'b0, gap};
      @(posedge clock);
      csr_we <= 1'b0;
      r_tpu = tpu;
      r_gap = gap;
   endtask

   task automatic test_directed_cases();
      // A unit length of zero counts as one tick, and the song restarts at once.
      set_registers(23'd0, 8'd0);
      send_item(tkmp_pkg::CMD_TICK, 2'd0);
      send_item(tkmp_pkg::CMD_KEY, 2'd0);
      send_item(tkmp_pkg::CMD_KEY, 2'd3);
      send_item(tkmp_pkg::CMD_TICK, 2'd0);
      send_item(tkmp_pkg::CMD_KEY, 2'd0);     // release of the sounding key
      send_item(tkmp_pkg::CMD_TICK, 2'd0);
      send_item(tkmp_pkg::CMD_SW1, 2'd0);
      send_item(tkmp_pkg::CMD_SW1, 2'd0);
      send_item(tkmp_pkg::CMD_SW1, 2'd0);     // octave wraps back to the lowest
      send_item(tkmp_pkg::CMD_KEY, 2'd1);
      send_item(tkmp_pkg::CMD_KEY, 2'd2);
      send_item(tkmp_pkg::CMD_SW2, 2'd0);
      send_item(tkmp_pkg::CMD_KEY, 2'd2);     // autoplay only flips the flag
      send_ticks(5);
      send_item(tkmp_pkg::CMD_SW1, 2'd3);
      send_ticks(2);
      send_item(tkmp_pkg::CMD_SW2, 2'd0);
      send_item(tkmp_pkg::CMD_TICK, 2'd0);
      send_item(tkmp_pkg::CMD_KEY, 2'd3);
   endtask

   // A held key that keeps sounding while the octave steps underneath it.
   task automatic test_held_key_tone();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      if (m_mode) send_item(tkmp_pkg::CMD_SW2, 2'd0);
      while (m_octave != 2'd2) send_item(tkmp_pkg::CMD_SW1, 2'd0);
      for (int k = 0; k < 4; k++)
         if (m_keys[k] != (k == 2)) send_item(tkmp_pkg::CMD_KEY, 2'(k));
      send_ticks(50);
      send_item(tkmp_pkg::CMD_SW1, 2'd0);
      send_item(tkmp_pkg::CMD_SW1, 2'd0);
      send_ticks(50);
   endtask

   // Short units so that a whole song, its gap and the restart fit in the run.
   task automatic test_song_playback();
      set_registers(23'd1, 8'd2);
      if (m_mode) send_item(tkmp_pkg::CMD_SW2, 2'd0);
      while (m_octave != 2'd2) send_item(tkmp_pkg::CMD_SW1, 2'd0);
      send_item(tkmp_pkg::CMD_SW2, 2'd0);
      while (m_song != 2'd3) send_item(tkmp_pkg::CMD_SW1, 2'd0);
      send_ticks(200);
   endtask

   // Events separated by runs of ticks, mostly short, some long enough to play
   // through a whole song and its gap.
   task automatic test_random_traffic(int n_items);
      int sent;
      int run;
      tkmp_pkg::cmd_type ev_cmd;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 5)
            ev_cmd = tkmp_pkg::CMD_TICK;
         else
            ev_cmd = tkmp_pkg::cmd_type'(2'($urandom_range(1, 3)));
         send_item(ev_cmd, 2'($urandom_range(0, 3)));
         if ($urandom_range(0, 99) < 20)
            run = $urandom_range(20, 200);
         else
            run = $urandom_range(0, 3);
         send_ticks(run);
         sent += run + 1;
      end
   endtask

   always @(posedge clock) begin : check_results
      status_type want;
      status_type got;
      if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         got = rsp_tdata[13:0];
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_tdata), 0);
         end else begin
            want = expected_status.pop_front();
            if (got.speaker != want.speaker)
               report_mismatch("speaker", got.speaker, want.speaker);
            if (got.tone_on != want.tone_on)
               report_mismatch("tone_on", got.tone_on, want.tone_on);
            if (got.mode != want.mode)
               report_mismatch("mode_now", got.mode, want.mode);
            if (got.octave != want.octave)
               report_mismatch("octave_now", got.octave, want.octave);
            if (got.song != want.song)
               report_mismatch("song_now", got.song, want.song);
            if (got.pos != want.pos)
               report_mismatch("note_pos", got.pos, want.pos);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      errors         = 0;
      results_seen   = 0;
      idle_cycles    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      m_mode    = 1'b0;
      m_octave  = 2'd0;
      m_song    = 2'd0;
      m_keys    = 4'b0000;
      m_speaker = 1'b0;
      r_tpu     = tkmp_pkg::TPU_RESET;
      r_gap     = tkmp_pkg::GAP_RESET;
      clear_playback();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      req_tuser  <= tkmp_pkg::CMD_TICK;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= tkmp_pkg::CSR_TICKS_PER_UNIT;
      csr_wdata  <= 23'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_held_key_tone();
      test_song_playback();

      set_registers(23'd1, 8'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_traffic(320);

      set_registers(23'd2, 8'd3);
      send_idle_pct  = 77;
      recv_stall_pct = 0;
      test_random_traffic(320);

      set_registers(23'd8388607, 8'd255);
      send_idle_pct  = 0;
      recv_stall_pct = 77;
      test_random_traffic(320);

      set_registers(23'($urandom_range(0, 3)), 8'($urandom_range(0, 5)));
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      test_random_traffic(320);

      drain_results();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
